// File: rtl/ibswm_pkg.sv
// ----------------------------------------------------------------------------
// ibswm_pkg
// Types and codes shared by the instruction break, step and watchdog monitor.
// ----------------------------------------------------------------------------
`default_nettype none

package ibswm_pkg;

  localparam logic [31:0] NONE_PC = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    ACT_DISPATCH = 3'd0,
    ACT_RESUME   = 3'd1,
    ACT_REARM    = 3'd2,
    ACT_CLEAR    = 3'd3,
    ACT_READ     = 3'd4
  } action_t;

  typedef enum logic [2:0] {
    REG_COV_LO     = 3'd0,
    REG_COV_HI     = 3'd1,
    REG_COV_ENABLE = 3'd2,
    REG_BREAK_ADDR = 3'd3,
    REG_BREAK_EN   = 3'd4,
    REG_SINGLE_STP = 3'd5,
    REG_WD_LIMIT   = 3'd6
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REASON_NONE     = 2'd0,
    REASON_BREAK    = 2'd1,
    REASON_WATCHDOG = 2'd2
  } reason_t;

  typedef enum logic [1:0] {
    TOK_NONE  = 2'd0,
    TOK_COVER = 2'd1,
    TOK_READ  = 2'd2
  } tok_kind_t;

  // Token that walks the coverage cell chain, one cell per cycle while the chain is not held.
  typedef struct packed {
    logic        valid;
    tok_kind_t   kind;
    logic [31:0] pc;
    logic [7:0]  idx;
    logic        found;
    logic        added;
    logic [31:0] data;
  } cov_tok_t;

  typedef struct packed {
    logic [31:0] break_addr;
    logic        break_enable;
    logic        single_step;
    logic [31:0] watchdog_limit;
  } dbg_cfg_t;

  typedef struct packed {
    logic        frozen;
    reason_t     reason;
    logic [31:0] stop_pc;
    logic [31:0] stop_total;
    logic        fired;
  } dbg_status_t;

endpackage

`default_nettype wire

// File: rtl/ibswm_cell.sv
// ----------------------------------------------------------------------------
// ibswm_cell
// One coverage slot: compares, appends or reads out, then passes the token on.
// ----------------------------------------------------------------------------
`default_nettype none

module ibswm_cell #(
  parameter int INDEX  = 0,
  parameter int FILL_W = 9
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   en,
  input  wire  [FILL_W-1:0]     fill,
  input  ibswm_pkg::cov_tok_t   tok_in,
  output ibswm_pkg::cov_tok_t   tok_out
);

  localparam logic [FILL_W-1:0] MY_SLOT = FILL_W'(INDEX);

  logic [31:0]         entry;
  logic                wr;
  ibswm_pkg::cov_tok_t tok_next;

  always_comb begin
    tok_next = tok_in;
    wr       = 1'b0;
    if (tok_in.valid) begin
      case (tok_in.kind)
        ibswm_pkg::TOK_COVER: begin
          if ((MY_SLOT < fill) && (entry == tok_in.pc)) begin
            tok_next.found = 1'b1;
          end else if ((MY_SLOT == fill) && !tok_in.found) begin
            wr             = 1'b1;
            tok_next.added = 1'b1;
          end
        end
        ibswm_pkg::TOK_READ: begin
          if (32'(tok_in.idx) == 32'(INDEX)) begin
            tok_next.data = entry;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out <= tok_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en && wr) begin
      entry <= tok_in.pc;
    end
  end

endmodule

`default_nettype wire

// File: rtl/ibswm_debug.sv
// ----------------------------------------------------------------------------
// ibswm_debug
// Stop logic: instruction watchdog, two-count single step and breakpoint.
// ----------------------------------------------------------------------------
`default_nettype none

module ibswm_debug (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     go,
  input  ibswm_pkg::action_t      action,
  input  wire  [31:0]             pc,
  input  ibswm_pkg::dbg_cfg_t     cfg,
  output ibswm_pkg::dbg_status_t  status
);

  logic [31:0]            ticks;
  logic [31:0]            ticks_next;
  logic [1:0]             countdown;
  logic [1:0]             countdown_next;
  ibswm_pkg::dbg_status_t status_next;
  logic [31:0]            ticks_inc;
  logic                   wd_on;

  assign ticks_inc = ticks + 32'd1;
  assign wd_on     = (cfg.watchdog_limit != 32'd0) && !status.frozen;

  always_comb begin
    status_next    = status;
    ticks_next     = ticks;
    countdown_next = countdown;
    if (go) begin
      unique case (action)
        ibswm_pkg::ACT_DISPATCH: begin
          if (wd_on) begin
            ticks_next = ticks_inc;
          end
          if (wd_on && (ticks_inc >= cfg.watchdog_limit)) begin
            status_next.fired   = 1'b1;
            status_next.frozen  = 1'b1;
            status_next.reason  = ibswm_pkg::REASON_WATCHDOG;
            status_next.stop_pc = pc;
          end else if ((countdown == 2'd1) ||
                       (cfg.break_enable && (pc == cfg.break_addr))) begin
            status_next.frozen     = 1'b1;
            status_next.reason     = ibswm_pkg::REASON_BREAK;
            status_next.stop_pc    = pc;
            status_next.stop_total = status.stop_total + 32'd1;
          end
          if (!(wd_on && (ticks_inc >= cfg.watchdog_limit)) && (countdown != 2'd0)) begin
            countdown_next = countdown - 2'd1;
          end
        end
        ibswm_pkg::ACT_RESUME: begin
          status_next.frozen = 1'b0;
          status_next.fired  = 1'b0;
          ticks_next         = 32'd0;
        end
        ibswm_pkg::ACT_REARM: begin
          status_next.frozen     = 1'b0;
          status_next.fired      = 1'b0;
          status_next.stop_total = 32'd0;
          status_next.reason     = ibswm_pkg::REASON_NONE;
          status_next.stop_pc    = ibswm_pkg::NONE_PC;
          ticks_next             = 32'd0;
          countdown_next         = cfg.single_step ? 2'd2 : 2'd0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      status.frozen     <= 1'b0;
      status.reason     <= ibswm_pkg::REASON_NONE;
      status.stop_pc    <= ibswm_pkg::NONE_PC;
      status.stop_total <= 32'd0;
      status.fired      <= 1'b0;
      ticks             <= 32'd0;
      countdown         <= 2'd0;
    end else begin
      status    <= status_next;
      ticks     <= ticks_next;
      countdown <= countdown_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/instruction_break_step_watchdog_monitor.sv
// ----------------------------------------------------------------------------
// instruction_break_step_watchdog_monitor
// Debug monitor on the instruction dispatch stream with address coverage.
// ----------------------------------------------------------------------------
// Each input beat on s_* carries an action, a pc and an entry index; every
// beat gives exactly one result beat on m_* with the stop status, the
// coverage counters and, for a read, one coverage entry. Registers are
// written through cfg_we, cfg_index and cfg_data; the user must write
// them only while the block is idle, which the block itself does not enforce.
// The coverage store is a chain of COV_DEPTH cells. A token carrying the
// beat walks the chain one cell per cycle while the chain is not held,
// checking for a duplicate, appending a new address in the first free cell
// or picking up the entry being read. The next input beat is taken only
// once the result is captured in the output register, so the block takes
// no new beat while a token is in the chain. The result register holds its
// beat while m_tready is low; a following result then waits at the end of
// the chain, which holds. Reset clears all status and counters at once.
// The stored addresses need no clearing pass, since only slots below the
// fill count are ever used.
`default_nettype none

module instruction_break_step_watchdog_monitor #(
  parameter int COV_DEPTH = 256
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  // action[2:0], pc[34:3], entry_index[42:35], zero fill
  input  wire  [47:0] s_tdata,
  output logic        m_tvalid,
  input  wire         m_tready,
  // frozen, hit_reason, last_hit_pc, hit_total, watchdog_fired,
  // covered_count, covered_total, covered_entry, entry_valid, zero fill
  output logic [((133 + $clog2(COV_DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [31:0] cfg_data
);

  localparam int FILL_W = $clog2(COV_DEPTH + 1);
  localparam int RES_W  = 133 + FILL_W;
  localparam int OUT_W  = ((RES_W + 7) / 8) * 8;
  localparam int CMP_W  = (FILL_W > 8) ? FILL_W : 8;

  ibswm_pkg::action_t    in_action;
  logic [31:0]           in_pc;
  logic [7:0]            in_idx;
  logic                  accept;

  logic [31:0]           cov_lo;
  logic [31:0]           cov_hi;
  logic                  cov_enable;
  ibswm_pkg::dbg_cfg_t   dbg_cfg;
  ibswm_pkg::dbg_status_t status;

  logic                  busy;
  logic [FILL_W-1:0]     fill;
  logic [31:0]           window_total;
  logic                  in_window;

  ibswm_pkg::cov_tok_t   tok [0:COV_DEPTH];
  logic [COV_DEPTH-1:0]  tok_valids;
  ibswm_pkg::cov_tok_t   tok_end;
  logic                  capture;
  logic                  chain_en;
  logic [FILL_W-1:0]     fill_after;
  logic                  rd_valid;

  ibswm_pkg::dbg_status_t out_status;
  logic [FILL_W-1:0]     out_count;
  logic [31:0]           out_total;
  logic [31:0]           out_entry;
  logic                  out_entry_valid;

  assign in_action = ibswm_pkg::action_t'(s_tdata[2:0]);
  assign in_pc     = s_tdata[34:3];
  assign in_idx    = s_tdata[42:35];
  assign s_tready  = !busy;
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cov_lo  <= 32'd0;
      cov_hi  <= 32'd0;
      cov_enable <= 1'b0;
      dbg_cfg <= '0;
    end else if (cfg_we) begin
      unique case (ibswm_pkg::cfg_reg_t'(cfg_index))
        ibswm_pkg::REG_COV_LO:     cov_lo <= cfg_data;
        ibswm_pkg::REG_COV_HI:     cov_hi <= cfg_data;
        ibswm_pkg::REG_COV_ENABLE: cov_enable <= cfg_data[0];
        ibswm_pkg::REG_BREAK_ADDR: dbg_cfg.break_addr <= cfg_data;
        ibswm_pkg::REG_BREAK_EN:   dbg_cfg.break_enable <= cfg_data[0];
        ibswm_pkg::REG_SINGLE_STP: dbg_cfg.single_step <= cfg_data[0];
        ibswm_pkg::REG_WD_LIMIT:   dbg_cfg.watchdog_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  ibswm_debug u_debug (
    .clk    (clk),
    .rst    (rst),
    .go     (accept),
    .action (in_action),
    .pc     (in_pc),
    .cfg    (dbg_cfg),
    .status (status)
  );

  assign in_window = cov_enable && (in_pc >= cov_lo) && (in_pc <= cov_hi);

  always_comb begin
    tok[0]       = '0;
    tok[0].valid = accept;
    tok[0].pc    = in_pc;
    tok[0].idx   = in_idx;
    if ((in_action == ibswm_pkg::ACT_DISPATCH) && in_window) begin
      tok[0].kind = ibswm_pkg::TOK_COVER;
    end else if (in_action == ibswm_pkg::ACT_READ) begin
      tok[0].kind = ibswm_pkg::TOK_READ;
    end else begin
      tok[0].kind = ibswm_pkg::TOK_NONE;
    end
  end

  assign tok_end  = tok[COV_DEPTH];
  assign capture  = tok_end.valid && (!m_tvalid || m_tready);
  assign chain_en = !(tok_end.valid && !capture);

  for (genvar i = 0; i < COV_DEPTH; i++) begin : g_cell
    ibswm_cell #(
      .INDEX  (i),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (chain_en),
      .fill    (fill),
      .tok_in  (tok[i]),
      .tok_out (tok[i+1])
    );
    assign tok_valids[i] = tok[i+1].valid;
  end

  assign fill_after = fill + FILL_W'(tok_end.kind == ibswm_pkg::TOK_COVER && tok_end.added);
  assign rd_valid   = (tok_end.kind == ibswm_pkg::TOK_READ) &&
                      (CMP_W'(tok_end.idx) < CMP_W'(fill));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy         <= 1'b0;
      fill         <= '0;
      window_total <= 32'd0;
      m_tvalid     <= 1'b0;
    end else begin
      if (accept) begin
        busy <= 1'b1;
        if (in_action == ibswm_pkg::ACT_CLEAR) begin
          fill         <= '0;
          window_total <= 32'd0;
        end else if ((in_action == ibswm_pkg::ACT_DISPATCH) && in_window) begin
          window_total <= window_total + 32'd1;
        end
      end
      if (capture) begin
        busy     <= 1'b0;
        fill     <= fill_after;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      out_status      <= status;
      out_count       <= fill_after;
      out_total       <= window_total;
      out_entry       <= rd_valid ? tok_end.data : 32'd0;
      out_entry_valid <= rd_valid;
    end
  end

  assign m_tdata = OUT_W'({out_entry_valid, out_entry, out_total, out_count,
                           out_status.fired, out_status.stop_total,
                           out_status.stop_pc, out_status.reason,
                           out_status.frozen});

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    32'(fill) <= 32'(COV_DEPTH))
    else $error("coverage fill count beyond store depth");

  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(tok_valids))
    else $error("more than one token in the coverage chain");

  a_token_busy: assert property (@(posedge clk) disable iff (rst)
    tok_end.valid |-> busy)
    else $error("token at chain end while block idle");

  a_frozen_reason: assert property (@(posedge clk) disable iff (rst)
    status.frozen |-> (status.reason != ibswm_pkg::REASON_NONE))
    else $error("frozen with no stop reason");

  a_read_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && out_entry_valid) |-> (out_count != '0))
    else $error("valid coverage entry with empty store");

endmodule

`default_nettype wire
